@@ rtl/core/ptfm_pkg.sv @@
`default_nettype none

package ptfm_pkg;

	// field widths
	localparam int MAC_W = 48;
	localparam int RUN_W = 32;
	localparam int THR_W = 16;

	// stream payload widths; the data widths are padded to whole bytes
	localparam int S_DATA_W = 56;  // dest_mac, tx_failed
	localparam int M_DATA_W = 88;  // notify, notify_mac, fail_run
	localparam int M_USER_W = 2;   // was_broadcast, table_full

	// broadcast destination: every address byte is 0xff
	localparam logic [MAC_W-1:0] BCAST_MAC = {(MAC_W / 8){8'hff}};

	// remainder unit: dividend bits retired per cycle
	localparam int REM_BPC   = 2;
	localparam int REM_STEPS = RUN_W / REM_BPC;
	localparam int REM_CNT_W = $clog2(REM_STEPS);

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

	// one row of the destination table
	typedef struct packed {
		logic             notified;
		logic [RUN_W-1:0] run;
		logic [MAC_W-1:0] mac;
	} entry_t;

	// status from the remainder unit to the sequencer
	typedef struct packed {
		logic done;
		logic zero;
	} rem_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/ptfm_table.sv @@
`default_nettype none

module ptfm_table #(
	parameter int TABLE_ENTRIES = 32
) (
	input  wire logic                                            clk,
	input  wire logic                                            rd_en,
	input  wire logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_addr,
	output ptfm_pkg::entry_t                                     rd_data,
	input  wire logic                                            wr_en,
	input  wire logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] wr_addr,
	input  wire ptfm_pkg::entry_t                                wr_data
);

	ptfm_pkg::entry_t mem_q [TABLE_ENTRIES];
	ptfm_pkg::entry_t rd_data_q;

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/core/ptfm_rem.sv @@
`default_nettype none

module ptfm_rem (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ptfm_pkg::RUN_W-1:0]    dividend,
	input  wire logic [ptfm_pkg::THR_W-1:0]    divisor,
	output ptfm_pkg::rem_stat_t                stat
);

	logic [ptfm_pkg::RUN_W-1:0]     dvd_q;
	logic [ptfm_pkg::THR_W-1:0]     rem_q;
	logic [ptfm_pkg::THR_W-1:0]     div_q;
	logic [ptfm_pkg::REM_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [ptfm_pkg::RUN_W-1:0]     dvd_nxt;
	logic [ptfm_pkg::THR_W-1:0]     rem_nxt;

	// restoring remainder, REM_BPC shift/compare/subtract steps per cycle
	always_comb begin
		logic [ptfm_pkg::THR_W:0] t;
		logic [ptfm_pkg::THR_W:0] d;
		rem_nxt = rem_q;
		dvd_nxt = dvd_q;
		d       = {1'b0, div_q};
		for (int k = 0; k < ptfm_pkg::REM_BPC; k++) begin
			t       = {rem_nxt, dvd_nxt[ptfm_pkg::RUN_W-1]};
			dvd_nxt = {dvd_nxt[ptfm_pkg::RUN_W-2:0], 1'b0};
			if (t >= d) begin
				rem_nxt = ptfm_pkg::THR_W'(t - d);
			end else begin
				rem_nxt = t[ptfm_pkg::THR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			div_q  <= ptfm_pkg::THR_RESET;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q  <= dividend;
				rem_q  <= '0;
				// a zero threshold counts as one
				div_q  <= (divisor == '0) ? ptfm_pkg::THR_RESET : divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				dvd_q <= dvd_nxt;
				rem_q <= rem_nxt;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ptfm_pkg::REM_CNT_W'(ptfm_pkg::REM_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (rem_q == '0);

endmodule

`default_nettype wire

@@ rtl/core/per_destination_tx_failure_monitor_top.sv @@
`default_nettype none

// Per-destination transmit failure monitor. Each input beat reports one sent frame
// (destination MAC, failed flag) and yields exactly one output beat. Broadcast frames
// are echoed with was_broadcast set; other destinations are tracked in a table of
// TABLE_ENTRIES rows, claimed in order and never released, so a new destination that
// finds all rows used is reported with table_full and not recorded. A failure bumps the
// entry's 32-bit run; notify rises when the run is a multiple of fail_threshold (zero
// acts as one). One frame is worked on at a time and s_tready is low meanwhile. Steps:
// a broadcast goes from the accept straight to the output state; otherwise the
// accept is followed by a serial read of the table through its single registered
// read port, one row a cycle over the rows in use, then a success goes through the
// update and output states and a failure also waits in the remainder state for the
// remainder unit, which retires 2 bits per cycle. A stalled output beat holds the
// block in its output state. The table needs no clearing pass after reset: a fill
// count marks which rows hold data.
module per_destination_tx_failure_monitor_top #(
	parameter int TABLE_ENTRIES = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration: fail_threshold
	input  wire logic                            cfg_we,
	input  wire logic [ptfm_pkg::THR_W-1:0]      cfg_wdata,
	// input stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [ptfm_pkg::S_DATA_W-1:0]   s_tdata,   // dest_mac[47:0], tx_failed[48]
	// output stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [ptfm_pkg::M_DATA_W-1:0]        m_tdata,   // notify[0], notify_mac[48:1],
	                                                        // fail_run[80:49]
	output logic [ptfm_pkg::M_USER_W-1:0]        m_tuser    // was_broadcast[0], table_full[1]
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPD,
		ST_MOD,
		ST_WB
	} state_t;

	state_t                          state_q;
	logic [ptfm_pkg::THR_W-1:0]      thr_q;
	logic [CNT_W-1:0]                fill_q;
	logic [CNT_W-1:0]                issue_q;
	logic                            pend_q;
	logic [IDX_W-1:0]                pend_idx_q;
	logic [IDX_W-1:0]                idx_q;
	logic [ptfm_pkg::MAC_W-1:0]      mac_q;
	logic                            failed_q;
	logic [ptfm_pkg::RUN_W-1:0]      run_q;
	logic                            notify_q;
	logic                            bcast_q;
	logic                            full_q;
	logic                            wr_q;
	logic                            m_tvalid_q;
	logic [ptfm_pkg::M_DATA_W-1:0]   m_tdata_q;
	logic [ptfm_pkg::M_USER_W-1:0]   m_tuser_q;

	logic                            in_acc;
	logic                            out_free;
	logic                            rd_en;
	logic                            rem_start;
	logic [ptfm_pkg::RUN_W-1:0]      run_inc;
	logic                            tbl_wr;
	ptfm_pkg::entry_t                rd_data;
	ptfm_pkg::entry_t                wr_data;
	ptfm_pkg::rem_stat_t             rem_stat;
	logic [ptfm_pkg::MAC_W-1:0]      in_mac;

	assign in_mac   = s_tdata[ptfm_pkg::MAC_W-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// serial table scan reads one used row per cycle
	assign rd_en     = (state_q == ST_SCAN) && (issue_q < fill_q);
	assign run_inc   = run_q + 1'b1;
	assign rem_start = (state_q == ST_UPD) && failed_q;

	assign tbl_wr           = (state_q == ST_WB) && wr_q && out_free;
	assign wr_data.notified = notify_q;
	assign wr_data.run      = run_q;
	assign wr_data.mac      = mac_q;

	// fail_threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ptfm_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			issue_q    <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
			idx_q      <= '0;
			mac_q      <= '0;
			failed_q   <= 1'b0;
			run_q      <= '0;
			notify_q   <= 1'b0;
			bcast_q    <= 1'b0;
			full_q     <= 1'b0;
			wr_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			// beat taken and no new one loaded this cycle
			if (m_tready && !((state_q == ST_WB) && out_free)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						mac_q    <= in_mac;
						failed_q <= s_tdata[ptfm_pkg::MAC_W];
						run_q    <= '0;
						notify_q <= 1'b0;
						full_q   <= 1'b0;
						wr_q     <= 1'b0;
						issue_q  <= '0;
						pend_q   <= 1'b0;
						bcast_q  <= (in_mac == ptfm_pkg::BCAST_MAC);
						state_q  <= (in_mac == ptfm_pkg::BCAST_MAC) ? ST_WB : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue next read, compare last one's data
					pend_q     <= rd_en;
					pend_idx_q <= issue_q[IDX_W-1:0];
					if (rd_en) begin
						issue_q <= issue_q + 1'b1;
					end
					if (pend_q && (rd_data.mac == mac_q)) begin
						idx_q   <= pend_idx_q;
						run_q   <= rd_data.run;
						wr_q    <= 1'b1;
						state_q <= ST_UPD;
					end else if (!pend_q && !rd_en) begin
						// miss: claim the next free row or report full
						if (fill_q == CNT_W'(TABLE_ENTRIES)) begin
							full_q  <= 1'b1;
							state_q <= ST_WB;
						end else begin
							idx_q   <= fill_q[IDX_W-1:0];
							fill_q  <= fill_q + 1'b1;
							run_q   <= '0;
							wr_q    <= 1'b1;
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					if (failed_q) begin
						run_q   <= run_inc;
						state_q <= ST_MOD;
					end else begin
						run_q    <= '0;
						notify_q <= 1'b0;
						state_q  <= ST_WB;
					end
				end
				ST_MOD: begin
					if (rem_stat.done) begin
						notify_q <= rem_stat.zero;
						state_q  <= ST_WB;
					end
				end
				ST_WB: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= ptfm_pkg::M_DATA_W'({run_q, mac_q, notify_q});
						m_tuser_q  <= {full_q, bcast_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	ptfm_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (rd_data),
		.wr_en   (tbl_wr),
		.wr_addr (idx_q),
		.wr_data (wr_data)
	);

	ptfm_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (run_inc),
		.divisor  (thr_q),
		.stat     (rem_stat)
	);

endmodule

`default_nettype wire

@@ rtl/core/ptfm_checker.sv @@
`default_nettype none

module ptfm_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [ptfm_pkg::M_DATA_W-1:0]   m_tdata,
	input wire logic [ptfm_pkg::M_USER_W-1:0]   m_tuser
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// one frame in flight: no accept right after an accept
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second frame taken while busy");

	// broadcast beat: echo is all ones, no notify, no run, not full
	a_bcast: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[48:1] == ptfm_pkg::BCAST_MAC) && !m_tdata[0]
			&& (m_tdata[80:49] == '0) && !m_tuser[1])
		else $error("bad broadcast beat");

	// full table beat: never notifies, run reads zero, address not broadcast
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tdata[0] && (m_tdata[80:49] == '0)
			&& (m_tdata[48:1] != ptfm_pkg::BCAST_MAC))
		else $error("bad table full beat");

endmodule

bind per_destination_tx_failure_monitor_top ptfm_checker u_ptfm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int TABLE_ENTRIES = 32;
	localparam int PHASE_FRAMES  = 155;
	localparam int POOL_SIZE     = 27;
	localparam int HOLD_CYCLES   = 400;
	localparam logic [ptfm_pkg::THR_W-1:0] PHASE_THR [6] =
		'{16'd3, 16'd0, 16'hFFFF, 16'd7, 16'd1, 16'd2};

	// one report as it leaves the block
	typedef struct packed {
		logic                       notify;
		logic [ptfm_pkg::MAC_W-1:0] mac;
		logic [ptfm_pkg::RUN_W-1:0] run;
		logic                       bcast;
		logic                       full;
	} tx_report_t;

	// directed frame; want holds the report when it is typed in (mac is filled on send)
	typedef struct packed {
		logic [ptfm_pkg::MAC_W-1:0] mac;
		logic                       failed;
		logic                       typed;
		tx_report_t                 want;
	} frame_row_t;

	// directed frames, run with the reset threshold of 1
	localparam frame_row_t SCRIPT [15] = '{
		'{48'h0000_0000_0000, 1'b1, 1'b1, '{1'b1, 48'h0, 32'd1, 1'b0, 1'b0}},
		'{48'h0000_0000_0000, 1'b1, 1'b1, '{1'b1, 48'h0, 32'd2, 1'b0, 1'b0}},
		'{48'h0000_0000_0000, 1'b0, 1'b1, '{1'b0, 48'h0, 32'd0, 1'b0, 1'b0}},
		'{48'h0000_0000_0000, 1'b1, 1'b1, '{1'b1, 48'h0, 32'd1, 1'b0, 1'b0}},
		'{48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, '{1'b0, 48'h0, 32'd0, 1'b1, 1'b0}},
		'{48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, '{1'b0, 48'h0, 32'd0, 1'b1, 1'b0}},
		'{48'hFFFF_FFFF_FFFE, 1'b1, 1'b1, '{1'b1, 48'h0, 32'd1, 1'b0, 1'b0}},
		'{48'h7FFF_FFFF_FFFF, 1'b1, 1'b1, '{1'b1, 48'h0, 32'd1, 1'b0, 1'b0}},
		'{48'h8000_0000_0000, 1'b0, 1'b1, '{1'b0, 48'h0, 32'd0, 1'b0, 1'b0}},
		'{48'h8000_0000_0000, 1'b1, 1'b1, '{1'b1, 48'h0, 32'd1, 1'b0, 1'b0}},
		'{48'hFFFF_FFFF_FFFE, 1'b1, 1'b1, '{1'b1, 48'h0, 32'd2, 1'b0, 1'b0}},
		'{48'h0123_4567_89AB, 1'b1, 1'b0, '0},
		'{48'hA5A5_A5A5_A5A5, 1'b0, 1'b0, '0},
		'{48'h5A5A_5A5A_5A5A, 1'b1, 1'b0, '0},
		'{48'h0123_4567_89AB, 1'b1, 1'b0, '0}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [ptfm_pkg::THR_W-1:0]    cfg_wdata = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [ptfm_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [ptfm_pkg::M_DATA_W-1:0] m_tdata;
	logic [ptfm_pkg::M_USER_W-1:0] m_tuser;

	// predictor state
	logic                       tbl_valid [TABLE_ENTRIES];
	logic [ptfm_pkg::MAC_W-1:0] tbl_mac [TABLE_ENTRIES];
	logic [ptfm_pkg::RUN_W-1:0] tbl_run [TABLE_ENTRIES];
	logic                       tbl_notified [TABLE_ENTRIES];
	logic [ptfm_pkg::THR_W-1:0] fail_thr = ptfm_pkg::THR_RESET;

	tx_report_t                 pending_reports [$];
	logic [ptfm_pkg::MAC_W-1:0] mac_pool [POOL_SIZE];
	int                         err_cnt = 0;
	int                         frames_sent = 0;
	int                         burst_left = 1;
	logic                       hold_req = 1'b0;

	always #5 clk = ~clk;

	per_destination_tx_failure_monitor_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// update the destination table for one frame and return its report
	function automatic tx_report_t predict_report(input logic [ptfm_pkg::MAC_W-1:0] mac,
			input logic failed);
		tx_report_t rep;
		int hit;
		int free_slot;
		logic [ptfm_pkg::RUN_W-1:0] divisor;
		rep = '0;
		rep.mac = mac;
		hit = -1;
		free_slot = -1;
		if (mac == ptfm_pkg::BCAST_MAC) begin
			rep.bcast = 1'b1;
			return rep;
		end
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (tbl_valid[i]) begin
				if (hit < 0 && tbl_mac[i] == mac)
					hit = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (hit < 0) begin
			if (free_slot < 0) begin
				rep.full = 1'b1;
				return rep;
			end
			// claim the lowest free row
			hit = free_slot;
			tbl_valid[hit] = 1'b1;
			tbl_mac[hit] = mac;
			tbl_run[hit] = '0;
			tbl_notified[hit] = 1'b0;
		end
		if (!failed) begin
			tbl_run[hit] = '0;
			tbl_notified[hit] = 1'b0;
		end else begin
			tbl_run[hit] = tbl_run[hit] + 1'b1;
			// a zero threshold acts as one
			divisor = (fail_thr == '0) ? ptfm_pkg::RUN_W'(1) : ptfm_pkg::RUN_W'(fail_thr);
			if (tbl_run[hit] % divisor == '0) begin
				rep.notify = 1'b1;
				tbl_notified[hit] = 1'b1;
			end
		end
		rep.run = tbl_run[hit];
		return rep;
	endfunction

	// offer one frame, log its report on accept, then maybe leave a gap
	task automatic push_frame(input logic [ptfm_pkg::MAC_W-1:0] mac, input logic failed,
			input logic typed, input tx_report_t want);
		tx_report_t predicted;
		int gap;
		s_tdata <= ptfm_pkg::S_DATA_W'({failed, mac});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = predict_report(mac, failed);
		if (typed) begin
			want.mac = mac;
			pending_reports.push_back(want);
		end else begin
			pending_reports.push_back(predicted);
		end
		frames_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop offering and wait for every outstanding report
	task automatic drain_reports();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [ptfm_pkg::THR_W-1:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		fail_thr = value;
	endtask

	// stimulus
	initial begin : sender
		int pick;
		int run_len;
		logic [ptfm_pkg::MAC_W-1:0] mac;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_mac[i] = '0;
			tbl_run[i] = '0;
			tbl_notified[i] = 1'b0;
		end
		// directed destinations first, then random ones
		mac_pool[0] = 48'h0000_0000_0000;
		mac_pool[1] = 48'hFFFF_FFFF_FFFE;
		mac_pool[2] = 48'h7FFF_FFFF_FFFF;
		mac_pool[3] = 48'h8000_0000_0000;
		mac_pool[4] = 48'h0123_4567_89AB;
		mac_pool[5] = 48'hA5A5_A5A5_A5A5;
		mac_pool[6] = 48'h5A5A_5A5A_5A5A;
		for (int i = 7; i < POOL_SIZE; i++)
			mac_pool[i] = {16'($urandom), 32'($urandom)};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (SCRIPT[i])
			push_frame(SCRIPT[i].mac, SCRIPT[i].failed, SCRIPT[i].typed, SCRIPT[i].want);

		// random part, one threshold per phase
		for (int p = 0; p < 6; p++) begin
			drain_reports();
			repeat (4) @(posedge clk);
			write_threshold(PHASE_THR[p]);
			for (int n = 0; n < PHASE_FRAMES; ) begin
				if (p == 0 && n >= 40 && n < 42)
					hold_req = 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 6) begin
					// broadcast noise
					push_frame(ptfm_pkg::BCAST_MAC, 1'($urandom), 1'b0, '0);
					n++;
				end else if (pick < 14 && frames_sent > 120) begin
					// unseen destination: claims a row or hits a full table
					push_frame({16'($urandom), 32'($urandom)}, 1'($urandom), 1'b0, '0);
					n++;
				end else begin
					// a run of frames to one known destination, mostly failures
					mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
					run_len = $urandom_range(1, 16);
					for (int k = 0; k < run_len; k++) begin
						push_frame(mac, $urandom_range(0, 99) < 85, 1'b0, '0);
						n++;
					end
				end
			end
		end

		drain_reports();
		repeat (100) @(posedge clk);
		if (pending_reports.size() != 0) begin
			$error("%0d reports never arrived", pending_reports.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// receiver: stall pattern changes every window, plus one long hold-off on request
	initial begin : receiver
		int window_left;
		int stall_pct;
		int hold_left;
		window_left = 0;
		stall_pct = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (window_left == 0) begin
					window_left = $urandom_range(20, 150);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 30;
						2: stall_pct = 70;
						default: stall_pct = 92;
					endcase
				end
				window_left--;
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// compare each output beat with the oldest predicted report
	always @(posedge clk) begin
		tx_report_t exp_rep;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected report beat: tdata=%h tuser=%b", m_tdata, m_tuser);
				err_cnt++;
			end else begin
				exp_rep = pending_reports.pop_front();
				if (m_tdata[0] !== exp_rep.notify) begin
					$error("notify: expected %0b, got %0b", exp_rep.notify, m_tdata[0]);
					err_cnt++;
				end
				if (m_tdata[48:1] !== exp_rep.mac) begin
					$error("notify_mac: expected %h, got %h", exp_rep.mac, m_tdata[48:1]);
					err_cnt++;
				end
				if (m_tdata[80:49] !== exp_rep.run) begin
					$error("fail_run: expected %0d, got %0d", exp_rep.run, m_tdata[80:49]);
					err_cnt++;
				end
				if (m_tuser[0] !== exp_rep.bcast) begin
					$error("was_broadcast: expected %0b, got %0b", exp_rep.bcast, m_tuser[0]);
					err_cnt++;
				end
				if (m_tuser[1] !== exp_rep.full) begin
					$error("table_full: expected %0b, got %0b", exp_rep.full, m_tuser[1]);
					err_cnt++;
				end
			end
		end
	end

	// run limit
	initial begin : watchdog
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
